>>> hdl/kdc_pkg.sv
// Shared types and constants for the keyword density classifier.
`timescale 1ns / 1ps
`default_nettype none
package kdc_pkg;

	// Item operation codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SCAN   = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// File classes
	localparam logic [1:0] CLASS_FIRST  = 2'd0;
	localparam logic [1:0] CLASS_SECOND = 2'd1;
	localparam logic [1:0] CLASS_NONE   = 2'd2;
	localparam logic [1:0] CLASS_NOSEP  = 2'd3;

	// Configuration register indexes
	localparam logic REG_FIRST_TH  = 1'b0;
	localparam logic REG_SECOND_TH = 1'b1;

	localparam logic [15:0] FIRST_TH_RST  = 16'd6;
	localparam logic [15:0] SECOND_TH_RST = 16'd5;

	localparam int          PCT_W      = 16;
	localparam int          PCT_SCALE  = 100;
	localparam logic [7:0]  BYTE_SPACE = 8'h20;
	localparam logic [7:0]  BYTE_NL    = 8'h0A;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] slot;
		logic [4:0] char_position;
		logic [7:0] data_byte;
		logic       set_id;
		logic [5:0] pattern_length;
	} kdc_in_t;

	typedef struct packed {
		logic [1:0]  file_class;
		logic [31:0] first_set_hits;
		logic [31:0] second_set_hits;
		logic [31:0] separator_count;
		logic [15:0] first_set_pct;
		logic [15:0] second_set_pct;
	} kdc_out_t;

	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] pct;
	} kdc_div_res_t;

endpackage
`default_nettype wire

>>> hdl/kdc_cell.sv
// One window cell: holds one recent text byte and compares it with a pattern character.
`timescale 1ns / 1ps
`default_nettype none
module kdc_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift,
	input  wire logic       clr,
	input  wire logic [7:0] din,
	input  wire logic [7:0] pchar,
	input  wire logic       en,
	output logic      [7:0] dout,
	output logic            ok
);
	logic [7:0] byte_q;

	// Hold the byte, take the neighbor's byte on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clr) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	// Positions outside the pattern always pass
	assign ok   = !en || (byte_q == pchar);
endmodule
`default_nettype wire

>>> hdl/kdc_div.sv
// Iterative percentage divider: hits*100/separators, saturating at 16 bits.
`timescale 1ns / 1ps
`default_nettype none
module kdc_div #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [COUNT_BITS-1:0] hits,
	input  wire logic [COUNT_BITS-1:0] seps,
	output kdc_pkg::kdc_div_res_t      res
);
	import kdc_pkg::*;

	localparam int NW = COUNT_BITS + 7;
	localparam int WW = COUNT_BITS + PCT_W;
	localparam int RW = COUNT_BITS + 1;

	localparam logic [1:0] DV_IDLE = 2'd0;
	localparam logic [1:0] DV_CHK  = 2'd1;
	localparam logic [1:0] DV_RUN  = 2'd2;

	logic [1:0]       phase_q;
	logic [NW-1:0]    num_q;
	logic [15:0]      low_q;
	logic [RW-1:0]    rem_q;
	logic [15:0]      quo_q;
	logic [3:0]       step_q;
	logic             done_q;
	logic [WW-1:0]    wide_num;
	logic [WW-1:0]    wide_den;
	logic [RW-1:0]    trial;
	logic             ge;

	// Saturation test and one restoring step
	always_comb begin
		wide_num = WW'(num_q);
		wide_den = {seps, 16'b0};
		trial    = {rem_q[RW-2:0], low_q[15]};
		ge       = trial >= {1'b0, seps};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DV_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				DV_IDLE: begin
					if (start) begin
						phase_q <= DV_CHK;
					end
				end
				DV_CHK: begin
					if (wide_num >= wide_den) begin
						done_q  <= 1'b1;
						phase_q <= DV_IDLE;
					end else begin
						step_q  <= '0;
						phase_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15) begin
						done_q  <= 1'b1;
						phase_q <= DV_IDLE;
					end
				end
				default: begin
					phase_q <= DV_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (phase_q == DV_IDLE && start) begin
			num_q <= NW'(hits) * NW'(PCT_SCALE);
		end
		if (phase_q == DV_CHK) begin
			if (wide_num >= wide_den) begin
				quo_q <= '1;
			end else begin
				rem_q <= RW'(num_q >> 16);
				low_q <= num_q[15:0];
			end
		end
		if (phase_q == DV_RUN) begin
			rem_q <= ge ? (trial - {1'b0, seps}) : trial;
			quo_q <= {quo_q[14:0], ge};
			low_q <= {low_q[14:0], 1'b0};
		end
	end

	assign res.done = done_q;
	assign res.pct  = quo_q;
endmodule
`default_nettype wire

>>> hdl/keyword_density_classifier_core.sv
// Top level of the keyword density classifier: pattern table, window cells and control.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries load, scan and end items.
//   Output channel (out_valid / out_stall / out_data) carries one result per end item.
//   Configuration: cfg_we writes cfg_data into threshold register cfg_index.
// Operation:
//   A scan item shifts the window cells and then walks the pattern table
//   one slot per cycle, set by the single read port of the pattern memory.
//   An end item runs the shared iterative divider once per set, first set
//   first, when separators were seen; without separators it skips the
//   divider and goes straight to the result.
//   in_stall is high while an item is in progress.
// Reset: thresholds return to 6 and 5, every slot reads as empty, totals,
//   window and line count clear. No clearing pass is needed.
// Stall: the result waits in the output register; loads and scans continue
//   to be taken, and a following end item holds the input stalled until the
//   waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none
module keyword_density_classifier_core #(
	parameter int PATTERN_SLOTS   = 256,
	parameter int MAX_PATTERN_LEN = 32,
	parameter int COUNT_BITS      = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  kdc_pkg::kdc_in_t in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output kdc_pkg::kdc_out_t out_data,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	import kdc_pkg::*;

	localparam int SLOT_W = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
	localparam int CHAR_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DIV1  = 3'd3;
	localparam logic [2:0] ST_DIV2  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]                 state_q;
	logic [15:0]                th1_q;
	logic [15:0]                th2_q;
	logic [MAX_PATTERN_LEN-1:0][7:0] char_mem [PATTERN_SLOTS];
	logic [LEN_W:0]             meta_mem [PATTERN_SLOTS];
	logic [PATTERN_SLOTS-1:0]   slot_vld_q;
	logic [SLOT_W-1:0]          slot_ctr_q;
	logic                       rd_vld_s1;
	logic                       mvld_s1;
	logic [MAX_PATTERN_LEN-1:0][7:0] row_s1;
	logic [LEN_W:0]             meta_s1;
	logic                       hit_vld_s2;
	logic                       hit_set_s2;
	logic [LEN_W-1:0]           lim_q;
	logic [LEN_W-1:0]           line_q;
	logic [LEN_W-1:0]           line_inc;
	logic [COUNT_BITS-1:0]      first_q;
	logic [COUNT_BITS-1:0]      second_q;
	logic [COUNT_BITS-1:0]      seps_q;
	logic [15:0]                p1_q;
	logic [15:0]                p2_q;
	logic                       out_valid_q;
	kdc_out_t                   out_q;

	logic                       in_acc;
	logic                       ld;
	logic [SLOT_W-1:0]          ld_addr;
	logic [LEN_W-1:0]           ld_len;
	logic                       chr_ok;
	logic [CHAR_W-1:0]          chr_idx;
	logic                       scan_acc;
	logic                       end_acc;
	logic                       is_sep;
	logic                       fin_go;
	logic [1:0]                 cls;
	logic [LEN_W-1:0]           len_s1;
	logic                       match_s1;
	logic [7:0]                 win [MAX_PATTERN_LEN];
	logic [MAX_PATTERN_LEN-1:0] ok_vec;
	logic                       div_start;
	logic [COUNT_BITS-1:0]      div_hits;
	kdc_div_res_t               div_res;

	function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
		logic [31:0] r;
		if (COUNT_BITS > 32 && (v >> 32) != '0) begin
			r = '1;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	// Decode the accepted item
	always_comb begin
		in_acc   = in_valid && !in_stall;
		ld       = in_acc && (in_data.op == OP_LOAD) && (int'(in_data.slot) < PATTERN_SLOTS);
		ld_addr  = SLOT_W'(in_data.slot);
		ld_len   = (int'(in_data.pattern_length) > MAX_PATTERN_LEN) ?
			LEN_W'(MAX_PATTERN_LEN) : LEN_W'(in_data.pattern_length);
		chr_ok   = int'(in_data.char_position) < MAX_PATTERN_LEN;
		chr_idx  = CHAR_W'(in_data.char_position);
		scan_acc = in_acc && (in_data.op == OP_SCAN);
		end_acc  = in_acc && (in_data.op == OP_END);
		is_sep   = (in_data.data_byte == BYTE_SPACE) || (in_data.data_byte == BYTE_NL);
		line_inc = (line_q < LEN_W'(MAX_PATTERN_LEN)) ? (line_q + LEN_W'(1)) : line_q;
		fin_go   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	assign in_stall = (state_q != ST_IDLE);

	// Threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th1_q <= FIRST_TH_RST;
			th2_q <= SECOND_TH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_TH:  th1_q <= cfg_data;
				REG_SECOND_TH: th2_q <= cfg_data;
				default:       th1_q <= th1_q;
			endcase
		end
	end

	// Pattern table: write on load, read one slot per cycle during a scan
	always_ff @(posedge clk) begin
		if (ld) begin
			meta_mem[ld_addr] <= {in_data.set_id, ld_len};
			if (chr_ok) begin
				char_mem[ld_addr][chr_idx] <= in_data.data_byte;
			end
		end
		row_s1  <= char_mem[slot_ctr_q];
		meta_s1 <= meta_mem[slot_ctr_q];
	end

	// Slot valid bits: an unloaded slot reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			mvld_s1    <= 1'b0;
		end else begin
			if (ld) begin
				slot_vld_q[ld_addr] <= 1'b1;
			end
			mvld_s1 <= slot_vld_q[slot_ctr_q];
		end
	end

	// Window cells, newest byte in cell zero
	assign len_s1 = mvld_s1 ? meta_s1[LEN_W-1:0] : '0;

	for (genvar j = 0; j < MAX_PATTERN_LEN; j++) begin : g_cell
		logic [LEN_W-1:0] offs;
		logic [7:0]       pchar;
		logic             en;
		logic [7:0]       din;

		assign en    = LEN_W'(j) < len_s1;
		assign offs  = len_s1 - LEN_W'(j + 1);
		assign pchar = row_s1[offs[CHAR_W-1:0]];
		if (j == 0) begin : g_head
			assign din = in_data.data_byte;
		end else begin : g_link
			assign din = win[j-1];
		end

		kdc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (scan_acc),
			.clr    (fin_go),
			.din    (din),
			.pchar  (pchar),
			.en     (en),
			.dout   (win[j]),
			.ok     (ok_vec[j])
		);
	end

	assign match_s1 = rd_vld_s1 && (len_s1 != '0) && (len_s1 <= lim_q) && (&ok_vec);

	// Shared divider
	assign div_start = (end_acc && (seps_q != '0)) || ((state_q == ST_DIV1) && div_res.done);
	assign div_hits  = (state_q == ST_DIV1) ? second_q : first_q;

	kdc_div #(
		.COUNT_BITS (COUNT_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.hits   (div_hits),
		.seps   (seps_q),
		.res    (div_res)
	);

	// Classify
	always_comb begin
		if (seps_q == '0) begin
			cls = CLASS_NOSEP;
		end else if (p1_q >= th1_q) begin
			cls = CLASS_FIRST;
		end else if (p2_q >= th2_q) begin
			cls = CLASS_SECOND;
		end else begin
			cls = CLASS_NONE;
		end
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			slot_ctr_q <= '0;
			rd_vld_s1  <= 1'b0;
			hit_vld_s2 <= 1'b0;
			hit_set_s2 <= 1'b0;
			lim_q      <= '0;
			line_q     <= '0;
			first_q    <= '0;
			second_q   <= '0;
			seps_q     <= '0;
			p1_q       <= '0;
			p2_q       <= '0;
		end else begin
			rd_vld_s1  <= (state_q == ST_SCAN);
			hit_vld_s2 <= match_s1;
			hit_set_s2 <= meta_s1[LEN_W];

			// Count a hit two stages behind the read
			if (hit_vld_s2) begin
				if (hit_set_s2) begin
					second_q <= (second_q == '1) ? second_q : second_q + COUNT_BITS'(1);
				end else begin
					first_q <= (first_q == '1) ? first_q : first_q + COUNT_BITS'(1);
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (scan_acc) begin
						lim_q      <= line_inc;
						line_q     <= (in_data.data_byte == BYTE_NL) ? '0 : line_inc;
						slot_ctr_q <= '0;
						if (is_sep && seps_q != '1) begin
							seps_q <= seps_q + COUNT_BITS'(1);
						end
						state_q <= ST_SCAN;
					end else if (end_acc) begin
						p1_q    <= '0;
						p2_q    <= '0;
						state_q <= (seps_q == '0) ? ST_FIN : ST_DIV1;
					end
				end
				ST_SCAN: begin
					if (slot_ctr_q == SLOT_W'(PATTERN_SLOTS - 1)) begin
						slot_ctr_q <= '0;
						state_q    <= ST_DRAIN;
					end else begin
						slot_ctr_q <= slot_ctr_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!rd_vld_s1 && !hit_vld_s2) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV1: begin
					if (div_res.done) begin
						p1_q    <= div_res.pct;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_res.done) begin
						p2_q    <= div_res.pct;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						first_q  <= '0;
						second_q <= '0;
						seps_q   <= '0;
						lim_q    <= '0;
						line_q   <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q.file_class      <= cls;
			out_q.first_set_hits  <= clip32(first_q);
			out_q.second_set_hits <= clip32(second_q);
			out_q.separator_count <= clip32(seps_q);
			out_q.first_set_pct   <= p1_q;
			out_q.second_set_pct  <= p2_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider finished outside a division state");

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit_vld_s2 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("pattern hit counted outside a scan");

	a_first_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIN) |=> (first_q >= $past(first_q)))
		else $error("first-set total dropped outside end of file");

	a_nosep_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(end_acc && seps_q == '0) |=> (state_q == ST_FIN))
		else $error("file without separators did not go straight to result");
`endif
endmodule
`default_nettype wire
